@@ rtl/bls_pkg.sv @@
package bls_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned SLOT_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_PEEK    = 3'd2,
    FN_CHANGE  = 3'd3,
    FN_DISPLAY = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OVER   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_WALK   = 2'd3
  } cmd_kind_e;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    cmd_kind_e                kind;
    status_e                  status;
    logic [SLOT_W-1:0]        addr;
    logic signed [DATA_W-1:0] wdata;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [SLOT_W-1:0]        slot;
    logic                     last;
  } res_t;

endpackage

@@ rtl/bls_ram.sv @@
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bls_cmd_fifo.sv @@
module bls_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bls_pkg::cmd_t wcmd_i,
  output logic          full_o,
  output logic          valid_o,
  output bls_pkg::cmd_t rcmd_o,
  input  logic          rd_i
);

  bls_pkg::cmd_t slot_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = ~wptr_q;
    end
    if (rd_i) begin
      rptr_d = ~rptr_q;
    end
    case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wptr_q] <= wcmd_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rcmd_o  = slot_q[rptr_q];

endmodule

@@ rtl/bls_front.sv @@
module bls_front #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [bls_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [bls_pkg::DATA_W-1:0] value_i,
  input  logic [bls_pkg::POS_W-1:0]         position_i,
  output logic                              enq_o,
  output bls_pkg::cmd_t                     cmd_o
);

  logic [CW-1:0] fill_q, fill_d;
  logic          known;
  logic          is_empty;
  logic          is_full;

  assign is_empty = (fill_q == '0);
  assign is_full  = (fill_q == CW'(DEPTH));

  // Track the fill level here so every item is resolved at acceptance.
  always_comb begin
    fill_d       = fill_q;
    known        = 1'b1;
    cmd_o.kind   = bls_pkg::CMD_STATUS;
    cmd_o.status = bls_pkg::ST_OK;
    cmd_o.addr   = '0;
    cmd_o.wdata  = value_i;
    unique case (bls_pkg::func_e'(func_i)) inside
      bls_pkg::FN_PUSH: begin
        if (is_full) begin
          cmd_o.status = bls_pkg::ST_OVER;
        end else begin
          cmd_o.kind = bls_pkg::CMD_WRITE;
          cmd_o.addr = bls_pkg::SLOT_W'(fill_q);
          fill_d     = fill_q + CW'(1);
        end
      end
      bls_pkg::FN_POP, bls_pkg::FN_PEEK: begin
        if (is_empty) begin
          cmd_o.status = bls_pkg::ST_EMPTY;
        end else begin
          cmd_o.kind = bls_pkg::CMD_READ;
          cmd_o.addr = bls_pkg::SLOT_W'(fill_q - CW'(1));
          if (bls_pkg::func_e'(func_i) == bls_pkg::FN_POP) begin
            fill_d = fill_q - CW'(1);
          end
        end
      end
      bls_pkg::FN_CHANGE: begin
        if (position_i == '0 || position_i > bls_pkg::POS_W'(fill_q)) begin
          cmd_o.status = bls_pkg::ST_BADPOS;
        end else begin
          cmd_o.kind = bls_pkg::CMD_WRITE;
          cmd_o.addr = bls_pkg::SLOT_W'(position_i - bls_pkg::POS_W'(1));
        end
      end
      bls_pkg::FN_DISPLAY: begin
        if (is_empty) begin
          cmd_o.status = bls_pkg::ST_EMPTY;
        end else begin
          cmd_o.kind = bls_pkg::CMD_WALK;
          cmd_o.addr = bls_pkg::SLOT_W'(fill_q - CW'(1));
        end
      end
      default: begin
        // drop unused codes
        known = 1'b0;
      end
    endcase
  end

  assign enq_o = accept_i && known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

endmodule

@@ rtl/bls_back.sv @@
module bls_back #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  bls_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  output bls_pkg::res_t res_o,
  input  logic          pop_i
);

  typedef struct packed {
    bls_pkg::status_e          status;
    logic [bls_pkg::SLOT_W-1:0] slot;
    logic                      last;
    logic                      use_ram;
  } stage_t;

  logic                              walking_q, walking_d;
  logic [bls_pkg::SLOT_W-1:0]        walk_q, walk_d;
  logic [bls_pkg::SLOT_W-1:0]        cur_addr;
  logic                              s1_v_q, s1_v_d;
  stage_t                            s1_q, s1_d;
  logic                              issue;
  logic                              out_pop;
  logic                              ram_we;
  logic                              ram_re;
  logic signed [bls_pkg::DATA_W-1:0] ram_rdata;
  bls_pkg::res_t                     out_q [2];
  bls_pkg::res_t                     s1_res;
  logic                              owptr_q, orptr_q;
  logic [1:0]                        ocnt_q, ocnt_d;

  assign out_pop  = pop_i && (ocnt_q != 2'd0);
  assign cur_addr = walking_q ? walk_q : cmd_i.addr;

  // Issue only if the beat landing next cycle is sure to find room.
  assign issue = cmd_valid_i &&
                 ((3'(ocnt_q) + 3'(s1_v_q)) < (3'd2 + 3'(out_pop)));

  assign ram_we = issue && (cmd_i.kind == bls_pkg::CMD_WRITE);
  assign ram_re = issue && (cmd_i.kind == bls_pkg::CMD_READ ||
                            cmd_i.kind == bls_pkg::CMD_WALK);

  always_comb begin
    walking_d      = walking_q;
    walk_d         = walk_q;
    cmd_pop_o      = 1'b0;
    s1_v_d         = issue;
    s1_d.status    = bls_pkg::ST_OK;
    s1_d.slot      = cur_addr;
    s1_d.last      = 1'b1;
    s1_d.use_ram   = 1'b0;
    if (issue) begin
      unique case (cmd_i.kind)
        bls_pkg::CMD_WRITE: begin
          cmd_pop_o = 1'b1;
        end
        bls_pkg::CMD_READ: begin
          s1_d.use_ram = 1'b1;
          cmd_pop_o    = 1'b1;
        end
        bls_pkg::CMD_STATUS: begin
          s1_d.status = cmd_i.status;
          s1_d.slot   = '0;
          cmd_pop_o   = 1'b1;
        end
        bls_pkg::CMD_WALK: begin
          // step down from the top entry, one beat per cycle while output has room
          s1_d.use_ram = 1'b1;
          s1_d.last    = (cur_addr == '0);
          if (cur_addr == '0) begin
            walking_d = 1'b0;
            cmd_pop_o = 1'b1;
          end else begin
            walking_d = 1'b1;
            walk_d    = cur_addr - bls_pkg::SLOT_W'(1);
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  bls_ram #(
    .WIDTH (bls_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (cur_addr[AW-1:0]),
    .wdata_i (cmd_i.wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_res.status = s1_q.status;
    s1_res.data   = s1_q.use_ram ? ram_rdata : '0;
    s1_res.slot   = s1_q.slot;
    s1_res.last   = s1_q.last;
  end

  always_comb begin
    case ({s1_v_q, out_pop})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q <= 1'b0;
      walk_q    <= '0;
      s1_v_q    <= 1'b0;
      owptr_q   <= 1'b0;
      orptr_q   <= 1'b0;
      ocnt_q    <= 2'd0;
    end else begin
      walking_q <= walking_d;
      walk_q    <= walk_d;
      s1_v_q    <= s1_v_d;
      ocnt_q    <= ocnt_d;
      if (s1_v_q) begin
        owptr_q <= ~owptr_q;
      end
      if (out_pop) begin
        orptr_q <= ~orptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= s1_d;
    end
    if (s1_v_q) begin
      out_q[owptr_q] <= s1_res;
    end
  end

  assign empty_o = (ocnt_q == 2'd0);
  assign res_o   = out_q[orptr_q];

endmodule

@@ rtl/bounded_lifo_stack.sv @@
// An accepted item passes the command FIFO, the read stage and the output queue.
// Push, pop, peek, change: one beat each; display streams one beat per stored
// entry, one per cycle while output has room, limited by the single RAM read port.
// Reset clears the fill level and all queues; stack entries are not cleared
// and need no clearing pass, so items are taken right after reset.
module bounded_lifo_stack #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [bls_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [bls_pkg::DATA_W-1:0] value_i,
  input  logic [bls_pkg::POS_W-1:0]         position_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        status_o,
  output logic signed [bls_pkg::DATA_W-1:0] data_o,
  output logic [bls_pkg::SLOT_W-1:0]        slot_o,
  output logic                              last_o
);

  logic          accept;
  logic          enq;
  bls_pkg::cmd_t enq_cmd;
  logic          cmd_valid;
  bls_pkg::cmd_t head_cmd;
  logic          cmd_pop;
  bls_pkg::res_t res;

  assign accept = push && !full;

  bls_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .value_i    (value_i),
    .position_i (position_i),
    .enq_o      (enq),
    .cmd_o      (enq_cmd)
  );

  bls_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (enq),
    .wcmd_i  (enq_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .rcmd_o  (head_cmd),
    .rd_i    (cmd_pop)
  );

  bls_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .res_o       (res),
    .pop_i       (pop)
  );

  assign status_o = res.status;
  assign data_o   = res.data;
  assign slot_o   = res.slot;
  assign last_o   = res.last;

endmodule

@@ tb/bounded_lifo_stack_test.sv @@
module bounded_lifo_stack_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam int unsigned STACK_DEPTH   = DEPTH_DEF;
  localparam int unsigned OP_TARGET     = 335;
  localparam int unsigned CALM_TAIL     = 60;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  // func codes the block must ignore
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } stack_op_t;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     push       = 1'b0;
  logic                     full;
  logic [FUNC_W-1:0]        func_i     = '0;
  logic signed [DATA_W-1:0] value_i    = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic                     empty;
  logic                     pop        = 1'b0;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] data_o;
  logic [SLOT_W-1:0]        slot_o;
  logic                     last_o;

  bounded_lifo_stack dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .value_i    (value_i),
    .position_i (position_i),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status_o),
    .data_o     (data_o),
    .slot_o     (slot_o),
    .last_o     (last_o)
  );

  // shadow copy of the stack
  logic signed [DATA_W-1:0] shadow_mem [STACK_DEPTH];
  int unsigned              shadow_fill = 0;

  stack_op_t   pending_ops [$];
  res_t        replies_due [$];
  stack_op_t   cur_op;
  res_t        want_beat;
  int unsigned gen_fill    = 0;
  int unsigned ops_queued  = 0;
  int unsigned send_hold   = 0;
  int unsigned recv_hold   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned mismatches  = 0;
  int unsigned ops_done    = 0;
  int unsigned ignored_ops = 0;
  int unsigned beats_seen  = 0;
  int unsigned full_hits   = 0;
  int unsigned over_hits   = 0;
  int unsigned empty_hits  = 0;
  int unsigned badpos_hits = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // queue one op and track the fill level it leaves behind
  function automatic void add_op(input logic [FUNC_W-1:0] func,
                                 input logic signed [DATA_W-1:0] value,
                                 input logic [POS_W-1:0] position);
    stack_op_t op;
    op.func     = func;
    op.value    = value;
    op.position = position;
    pending_ops.push_back(op);
    if (func == FN_PUSH && gen_fill < STACK_DEPTH) gen_fill++;
    if (func == FN_POP && gen_fill > 0) gen_fill--;
    if (func <= FN_DISPLAY) ops_queued++;
  endfunction

  function automatic void queue_reply(input status_e st, input logic signed [DATA_W-1:0] d,
                                      input int unsigned slot, input logic lst);
    res_t r;
    r.status = st;
    r.data   = d;
    r.slot   = slot[SLOT_W-1:0];
    r.last   = lst;
    replies_due.push_back(r);
  endfunction

  function automatic void step_shadow_stack(input stack_op_t op);
    int unsigned k;
    if (op.func <= FN_DISPLAY) ops_done++;
    case (op.func)
      FN_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          queue_reply(ST_OVER, '0, 0, 1'b1);
          over_hits++;
        end else begin
          shadow_mem[shadow_fill] = op.value;
          queue_reply(ST_OK, '0, shadow_fill, 1'b1);
          shadow_fill++;
          if (shadow_fill == STACK_DEPTH) full_hits++;
        end
      end
      FN_POP, FN_PEEK: begin
        if (shadow_fill == 0) begin
          queue_reply(ST_EMPTY, '0, 0, 1'b1);
          empty_hits++;
        end else begin
          queue_reply(ST_OK, shadow_mem[shadow_fill-1], shadow_fill - 1, 1'b1);
          if (op.func == FN_POP) shadow_fill--;
        end
      end
      FN_CHANGE: begin
        if (op.position == 0 || op.position > shadow_fill) begin
          queue_reply(ST_BADPOS, '0, 0, 1'b1);
          badpos_hits++;
        end else begin
          shadow_mem[op.position-1] = op.value;
          queue_reply(ST_OK, '0, op.position - 1, 1'b1);
        end
      end
      FN_DISPLAY: begin
        if (shadow_fill == 0) begin
          queue_reply(ST_EMPTY, '0, 0, 1'b1);
          empty_hits++;
        end else begin
          // walk from the top entry down to the bottom one
          for (k = shadow_fill; k > 0; k--)
            queue_reply(ST_OK, shadow_mem[k-1], k - 1, k == 1);
        end
      end
      default: ignored_ops++;
    endcase
  endfunction

  // driver: one beat per accepted op
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) step_shadow_stack(cur_op);
      if (!push || !full) begin
        if (send_hold != 0) begin
          push <= 1'b0;
          send_hold--;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          push       <= 1'b1;
          func_i     <= cur_op.func;
          value_i    <= cur_op.value;
          position_i <= cur_op.position;
          if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
            send_hold = $urandom_range(1, 12);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result beat: status %0d data %0d slot %0d last %0d",
                 status_o, data_o, slot_o, last_o);
          mismatches++;
        end else begin
          want_beat = replies_due.pop_front();
          beats_seen++;
          if (status_o !== want_beat.status) begin
            $error("status mismatch: expected %0d, actual %0d", want_beat.status, status_o);
            mismatches++;
          end
          if (data_o !== want_beat.data) begin
            $error("data mismatch: expected %0d, actual %0d", want_beat.data, data_o);
            mismatches++;
          end
          if (slot_o !== want_beat.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want_beat.slot, slot_o);
            mismatches++;
          end
          if (last_o !== want_beat.last) begin
            $error("last mismatch: expected %0d, actual %0d", want_beat.last, last_o);
            mismatches++;
          end
        end
      end
      if (recv_hold != 0) begin
        pop <= 1'b0;
        recv_hold--;
      end else begin
        pop <= 1'b1;
        if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          recv_hold = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, replies_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned      roll;
    logic [POS_W-1:0] pos;
    bit               filled_once;

    filled_once = 1'b0;

    // empty-stack corner cases
    add_op(FN_POP, '0, '0);
    add_op(FN_PEEK, '0, '0);
    add_op(FN_DISPLAY, '0, '0);
    add_op(FN_CHANGE, 32'sd5, 7'd0);
    add_op(FN_CHANGE, 32'sd5, 7'd1);
    // extreme words, position ignored by push
    add_op(FN_PUSH, {1'b0, {(DATA_W-1){1'b1}}}, 7'd64);
    add_op(FN_PUSH, {1'b1, {(DATA_W-1){1'b0}}}, 7'd127);
    add_op(FN_PUSH, '0, '0);
    add_op(FN_PUSH, '1, 7'd63);
    add_op(FN_PEEK, '0, '0);
    add_op(FN_DISPLAY, '0, '0);
    // change at bottom, top, just above top, far above, zero
    add_op(FN_CHANGE, 32'sh5a5a_a5a5, 7'd1);
    add_op(FN_CHANGE, -32'sd77, 7'd4);
    add_op(FN_CHANGE, 32'sd1, 7'd5);
    add_op(FN_CHANGE, 32'sd1, 7'd64);
    add_op(FN_CHANGE, 32'sd1, 7'd0);
    for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++) add_op(FUNC_W'(f), pick_word(), 7'd64);
    add_op(FN_DISPLAY, '0, '0);
    repeat (5) add_op(FN_POP, '0, '0);
    add_op(FN_DISPLAY, '0, '0);

    while (ops_queued < OP_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 2 || (!filled_once && ops_queued > 150)) begin
        // fill to the brim, then hit overflow and the top slot
        filled_once = 1'b1;
        while (gen_fill < STACK_DEPTH)
          add_op(FN_PUSH, pick_word(), POS_W'($urandom_range(0, 127)));
        add_op(FN_PUSH, pick_word(), '0);
        add_op(FN_DISPLAY, '0, '0);
        add_op(FN_CHANGE, pick_word(), POS_W'(STACK_DEPTH));
        add_op(FN_PEEK, '0, '0);
        add_op(FN_PUSH, pick_word(), '0);
      end else if (roll < 5) begin
        // drain, then poke the empty stack
        while (gen_fill > 0)
          add_op(FN_POP, pick_word(), POS_W'($urandom_range(0, STACK_DEPTH)));
        add_op(FN_POP, '0, '0);
        add_op(FN_PEEK, '0, '0);
        add_op(FN_DISPLAY, '0, '0);
        add_op(FN_CHANGE, pick_word(), 7'd1);
      end else if (roll < 9) begin
        add_op(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), pick_word(),
               POS_W'($urandom_range(0, STACK_DEPTH)));
      end else begin
        roll = $urandom_range(0, 99);
        if (gen_fill > 0 && $urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(1, gen_fill));
        else pos = POS_W'($urandom_range(0, STACK_DEPTH));
        if (roll < 35)      add_op(FN_PUSH, pick_word(), pos);
        else if (roll < 55) add_op(FN_POP, pick_word(), pos);
        else if (roll < 65) add_op(FN_PEEK, pick_word(), pos);
        else if (roll < 87) add_op(FN_CHANGE, pick_word(), pos);
        else                add_op(FN_DISPLAY, pick_word(), pos);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || push) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d stack ops plus %0d ignored codes, checked %0d result beats",
             ops_done, ignored_ops, beats_seen);
    $display("stack filled %0d times; overflow %0d, empty %0d, bad position %0d",
             full_hits, over_hits, empty_hits, badpos_hits);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ bounded_lifo_stack.f @@
rtl/bls_pkg.sv
rtl/bls_ram.sv
rtl/bls_cmd_fifo.sv
rtl/bls_front.sv
rtl/bls_back.sv
rtl/bounded_lifo_stack.sv
tb/bounded_lifo_stack_test.sv
